// ----- rtl/u8sc_pkg.sv -----
// Shared types, constants and the script range classifier for the
// UTF-8 decode / script classify core. No dependencies.
`default_nettype none

package u8sc_pkg;

  typedef logic [20:0] cp_t;
  typedef logic [1:0]  class_t;
  typedef logic [1:0]  cfg_index_t;

  localparam class_t CLASS_LATIN = 2'd0;
  localparam class_t CLASS_JP    = 2'd1;
  localparam class_t CLASS_KR    = 2'd2;
  localparam class_t CLASS_SC    = 2'd3;

  localparam cfg_index_t REG_JP_AVAILABLE = 2'd0;
  localparam cfg_index_t REG_KR_AVAILABLE = 2'd1;
  localparam cfg_index_t REG_SC_AVAILABLE = 2'd2;

  localparam cp_t REPLACEMENT_CP = 21'h00FFFD;

  localparam int unsigned MID_DEPTH_DEFAULT = 4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_t;

  typedef struct packed {
    cp_t    code_point;
    class_t script_class;
    logic   new_run;
    logic   bad_sequence;
    logic   last_result;
  } result_t;

  // decoded codepoint travelling from decoder to classifier
  typedef struct packed {
    cp_t  code_point;
    logic bad_sequence;
    logic last_result;
    logic text_first;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } token_pair_t;

  typedef struct packed {
    logic jp;
    logic kr;
    logic sc;
  } avail_t;

  function automatic logic in_rng(input cp_t c, input cp_t lo, input cp_t hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic class_t classify(input cp_t c, input avail_t av);
    logic   kr_hit;
    logic   cjk_hit;
    logic   bpmf_hit;
    class_t cls;
    kr_hit = in_rng(c, 21'h01100, 21'h011FF) || in_rng(c, 21'h0302E, 21'h0302F) ||
             in_rng(c, 21'h03131, 21'h0318E) || in_rng(c, 21'h0A960, 21'h0A97C) ||
             in_rng(c, 21'h0AC00, 21'h0D7A3) || in_rng(c, 21'h0D7B0, 21'h0D7C6) ||
             in_rng(c, 21'h0D7CB, 21'h0D7FB);
    cjk_hit = in_rng(c, 21'h03000, 21'h030FF) || in_rng(c, 21'h03400, 21'h04DBF) ||
              in_rng(c, 21'h04E00, 21'h09FFF) || in_rng(c, 21'h0F900, 21'h0FAFF) ||
              in_rng(c, 21'h0FF00, 21'h0FFEF) || in_rng(c, 21'h20000, 21'h2A6DF) ||
              in_rng(c, 21'h2A700, 21'h2CEAF);
    bpmf_hit = in_rng(c, 21'h002EA, 21'h002EB) || in_rng(c, 21'h03100, 21'h0312F) ||
               in_rng(c, 21'h031A0, 21'h031BF);
    if (kr_hit) begin
      cls = av.kr ? CLASS_KR : CLASS_LATIN;
    end else if (cjk_hit) begin
      cls = av.jp ? CLASS_JP : (av.sc ? CLASS_SC : CLASS_LATIN);
    end else if (bpmf_hit) begin
      cls = av.sc ? CLASS_SC : CLASS_LATIN;
    end else begin
      cls = CLASS_LATIN;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/utf8_decode_script_classify_core.sv -----
// UTF-8 decoder with script class and run-start tagging.
// A byte's results are registered in the token queue and then in the result queue before they show at result.
// Throughput: one byte per cycle while full is low; one result per cycle leaves the
// classifier while its result queue has room, so input is held off once the token queue is nearly full.
// Reset (synchronous rst): decoder cleared, at text start, all classes available.
// Depends on u8sc_pkg, u8sc_front, u8sc_midq, u8sc_back.
`default_nettype none

module utf8_decode_script_classify_core
  import u8sc_pkg::*;
#(
  parameter int unsigned MID_DEPTH = MID_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  text_t      text,
  output logic       empty,
  input  logic       pop,
  output result_t    result,
  input  logic       cfg_write,
  input  cfg_index_t cfg_index,
  input  logic       cfg_data
);

  logic        accept;
  token_pair_t pair;
  logic        mid_empty;
  logic        mid_pop;
  token_t      mid_head;

  assign accept = push && !full;

  u8sc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .text   (text),
    .pair   (pair)
  );

  u8sc_midq #(
    .DEPTH (MID_DEPTH)
  ) u_midq (
    .clk   (clk),
    .rst   (rst),
    .wr_en (accept),
    .pair  (pair),
    .full  (full),
    .empty (mid_empty),
    .rd_en (mid_pop),
    .head  (mid_head)
  );

  u8sc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_empty (mid_empty),
    .tok       (mid_head),
    .tok_pop   (mid_pop),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

// ----- rtl/u8sc_front.sv -----
// UTF-8 byte decoder: holds the partial sequence and emits zero, one or
// two decoded codepoints per accepted byte. Depends on u8sc_pkg.
`default_nettype none

module u8sc_front
  import u8sc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  text_t       text,
  output token_pair_t pair
);

  cp_t        partial;
  logic [1:0] remaining;
  logic       at_start;

  cp_t        partial_next;
  logic [1:0] remaining_next;
  logic [7:0] b;
  logic       eot;
  logic       do_lead;
  logic       e0v, e1v, e2v;
  cp_t        e1cp;
  logic       e1bad;
  cp_t        shifted;
  token_t     t0, t1, t2;

  assign b   = text.text_byte;
  assign eot = text.end_of_text;
  assign shifted = {partial[14:0], b[5:0]};

  always_comb begin
    e0v            = 1'b0;
    e1v            = 1'b0;
    e1cp           = {13'd0, b};
    e1bad          = 1'b0;
    do_lead        = 1'b0;
    partial_next   = partial;
    remaining_next = remaining;
    if (remaining != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        partial_next   = shifted;
        remaining_next = remaining - 2'd1;
        if (remaining == 2'd1) begin
          e1v          = 1'b1;
          e1cp         = shifted;
          partial_next = '0;
        end
      end else begin
        e0v            = 1'b1;
        partial_next   = '0;
        remaining_next = 2'd0;
        do_lead        = 1'b1;
      end
    end else begin
      do_lead = 1'b1;
    end
    if (do_lead) begin
      priority if (!b[7]) begin
        e1v = 1'b1;
      end else if (!b[6]) begin
        e1v   = 1'b1;
        e1cp  = REPLACEMENT_CP;
        e1bad = 1'b1;
      end else if (!b[5]) begin
        partial_next   = {16'd0, b[4:0]};
        remaining_next = 2'd1;
      end else if (!b[4]) begin
        partial_next   = {17'd0, b[3:0]};
        remaining_next = 2'd2;
      end else begin
        partial_next   = {18'd0, b[2:0]};
        remaining_next = 2'd3;
      end
    end
    e2v = eot && (remaining_next != 2'd0);
    if (eot) begin
      partial_next   = '0;
      remaining_next = 2'd0;
    end
  end

  always_comb begin
    t0 = '{code_point: REPLACEMENT_CP, bad_sequence: 1'b1,
           last_result: 1'b0, text_first: 1'b0};
    t1 = '{code_point: e1cp, bad_sequence: e1bad,
           last_result: 1'b0, text_first: 1'b0};
    t2 = t0;
    pair.count = {1'b0, e0v} + {1'b0, e1v} + {1'b0, e2v};
    pair.tok0  = e0v ? t0 : (e1v ? t1 : t2);
    pair.tok1  = (e0v && e1v) ? t1 : t2;
    pair.tok0.text_first = at_start;
    // end flag goes on whichever token is the final one
    pair.tok0.last_result = eot && (pair.count == 2'd1);
    pair.tok1.last_result = eot && (pair.count == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial   <= '0;
      remaining <= 2'd0;
      at_start  <= 1'b1;
    end else if (accept) begin
      partial   <= partial_next;
      remaining <= remaining_next;
      if (eot) begin
        at_start <= 1'b1;
      end else if (pair.count != 2'd0) begin
        at_start <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/u8sc_midq.sv -----
// Token queue between decoder and classifier; takes up to two tokens
// per cycle, gives one. Depends on u8sc_pkg.
`default_nettype none

module u8sc_midq
  import u8sc_pkg::*;
#(
  parameter int unsigned DEPTH = MID_DEPTH_DEFAULT  // at least 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  token_pair_t pair,
  output logic        full,
  output logic        empty,
  input  logic        rd_en,
  output token_t      head
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);

  token_t          store [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [PtrW-1:0] wr_ptr1;
  logic [PtrW-1:0] wr_ptr2;
  logic [PtrW-1:0] rd_ptr1;
  logic [1:0]      n_wr;
  logic            do_rd;

  function automatic logic [PtrW-1:0] incr(input logic [PtrW-1:0] p);
    return (p == LastIdx) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_ptr1 = incr(wr_ptr);
  assign wr_ptr2 = incr(wr_ptr1);
  assign rd_ptr1 = incr(rd_ptr);
  assign n_wr    = wr_en ? pair.count : 2'd0;
  assign empty   = (count == '0);
  assign full    = (count > CntW'(DEPTH - 2));
  assign do_rd   = rd_en && !empty;
  assign head    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      store[wr_ptr] <= pair.tok0;
    end
    if (n_wr == 2'd2) begin
      store[wr_ptr1] <= pair.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      unique case (n_wr)
        2'd1:    wr_ptr <= wr_ptr1;
        2'd2:    wr_ptr <= wr_ptr2;
        default: wr_ptr <= wr_ptr;
      endcase
      if (do_rd) begin
        rd_ptr <= rd_ptr1;
      end
      count <= count + CntW'(n_wr) - CntW'(do_rd);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/u8sc_back.sv -----
// Script classifier and run tracker with a two-entry result queue;
// holds the font availability registers. Depends on u8sc_pkg.
`default_nettype none

module u8sc_back
  import u8sc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       tok_empty,
  input  token_t     tok,
  output logic       tok_pop,
  input  logic       cfg_write,
  input  cfg_index_t cfg_index,
  input  logic       cfg_data,
  output logic       empty,
  input  logic       pop,
  output result_t    result
);

  avail_t     avail;
  class_t     prev_class;
  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  class_t     cls;
  logic       do_pop;
  result_t    res_next;

  assign cls     = classify(tok.code_point, avail);
  assign tok_pop = !tok_empty && (count != 2'd2);
  assign empty   = (count == 2'd0);
  assign do_pop  = pop && !empty;
  assign result  = slot[rd_ptr];

  always_comb begin
    res_next.code_point   = tok.code_point;
    res_next.script_class = cls;
    res_next.new_run      = tok.text_first || (cls != prev_class);
    res_next.bad_sequence = tok.bad_sequence;
    res_next.last_result  = tok.last_result;
  end

  always_ff @(posedge clk) begin
    if (tok_pop) begin
      slot[wr_ptr] <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avail      <= '{jp: 1'b1, kr: 1'b1, sc: 1'b1};
      prev_class <= CLASS_LATIN;
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
      count      <= 2'd0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_JP_AVAILABLE: avail.jp <= cfg_data;
          REG_KR_AVAILABLE: avail.kr <= cfg_data;
          REG_SC_AVAILABLE: avail.sc <= cfg_data;
          default:          avail    <= avail;
        endcase
      end
      if (tok_pop) begin
        prev_class <= cls;
        wr_ptr     <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, tok_pop} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire
